// ----- src/rgb_led_pulse_width_serializer_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RGB LED pulse-width serialiser
// Shared property forms, one per assertion at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_PULSE_WIDTH_SERIALIZER_DEFINES_SVH
`define RGB_LED_PULSE_WIDTH_SERIALIZER_DEFINES_SVH

// same-cycle implication
`define RLPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rlps_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB LED pulse-width serialiser package
// Widths, register indices, reset values, opcodes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rlps_pkg;

    localparam int COLOUR_BITS = 24;
    localparam int SLOT_W      = 6;
    localparam int TICK_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // register indices
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_HIGH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAD_SLOTS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAIL_SLOTS = 3'd4;

    localparam logic [7:0] RST_BIT_PERIOD  = 8'd80;
    localparam logic [7:0] RST_ZERO_HIGH   = 8'd20;
    localparam logic [7:0] RST_ONE_HIGH    = 8'd60;
    localparam logic [2:0] RST_LEAD_SLOTS  = 3'd2;
    localparam logic [2:0] RST_TRAIL_SLOTS = 3'd2;

    // opcodes carried in tuser
    localparam logic OP_TICK       = 1'b0;
    localparam logic OP_SET_COLOUR = 1'b1;

    typedef struct packed {
        logic frame_done;
        logic busy_res;
        logic line_level;
    } rlps_result_t;

endpackage

`default_nettype wire

// ----- src/rlps_engine.sv -----
// ----------------------------------------------------------------------------
// RGB LED pulse-width serialiser engine
// Holds the configuration and frame state and advances it by one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rlps_engine
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rlps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rlps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                step,
    input  wire logic                                opcode,
    input  wire logic [7:0]                          red,
    input  wire logic [7:0]                          green,
    input  wire logic [7:0]                          blue,
    output rlps_pkg::rlps_result_t                   result
);
    import rlps_pkg::*;

    logic [7:0] bit_period_reg;
    logic [7:0] zero_high_reg;
    logic [7:0] one_high_reg;
    logic [2:0] lead_slots_reg;
    logic [2:0] trail_slots_reg;

    logic [23:0]            pending_colour_reg, pending_colour_next;
    logic                   colour_waiting_reg, colour_waiting_next;
    logic                   sending_reg, sending_next;
    logic [COLOUR_BITS-1:0] bit_shifter_reg, bit_shifter_next;
    logic [SLOT_W-1:0]      slot_index_reg, slot_index_next;
    logic [TICK_W-1:0]      tick_in_slot_reg, tick_in_slot_next;
    logic                   line_reg, line_next;
    logic                   done;

    logic                   start;
    logic [COLOUR_BITS-1:0] shifter_cur;
    logic [SLOT_W-1:0]      slot_cur;
    logic [SLOT_W-1:0]      slot_inc;
    logic [TICK_W-1:0]      tick_cur;
    logic [SLOT_W-1:0]      lead_ext;
    logic [SLOT_W-1:0]      data_end;
    logic [SLOT_W-1:0]      total;
    logic                   data_slot;
    logic [TICK_W-1:0]      last_tick;
    logic [TICK_W-1:0]      high_ticks;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg  <= RST_BIT_PERIOD;
            zero_high_reg   <= RST_ZERO_HIGH;
            one_high_reg    <= RST_ONE_HIGH;
            lead_slots_reg  <= RST_LEAD_SLOTS;
            trail_slots_reg <= RST_TRAIL_SLOTS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIT_PERIOD:  bit_period_reg  <= cfg_data;
                CFG_ZERO_HIGH:   zero_high_reg   <= cfg_data;
                CFG_ONE_HIGH:    one_high_reg    <= cfg_data;
                CFG_LEAD_SLOTS:  lead_slots_reg  <= cfg_data[2:0];
                CFG_TRAIL_SLOTS: trail_slots_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // a waiting colour starts its frame on the tick itself
    assign start       = !sending_reg && colour_waiting_reg;
    assign shifter_cur = start ? COLOUR_BITS'(pending_colour_reg) : bit_shifter_reg;
    assign slot_cur    = start ? '0 : slot_index_reg;
    assign tick_cur    = start ? '0 : tick_in_slot_reg;
    assign slot_inc    = slot_cur + SLOT_W'(1);
    assign lead_ext    = SLOT_W'(lead_slots_reg);
    assign data_end    = lead_ext + SLOT_W'(COLOUR_BITS);
    assign total       = data_end + SLOT_W'(trail_slots_reg);
    assign data_slot   = (slot_cur >= lead_ext) && (slot_cur < data_end);
    assign last_tick   = bit_period_reg - TICK_W'(1);
    assign high_ticks  = shifter_cur[COLOUR_BITS-1] ? one_high_reg : zero_high_reg;

    always_comb
    begin
        pending_colour_next = pending_colour_reg;
        colour_waiting_next = colour_waiting_reg;
        sending_next        = sending_reg;
        bit_shifter_next    = bit_shifter_reg;
        slot_index_next     = slot_index_reg;
        tick_in_slot_next   = tick_in_slot_reg;
        line_next           = line_reg;
        done                = 1'b0;

        if (opcode == OP_SET_COLOUR)
        begin
            pending_colour_next = {green, red, blue};
            colour_waiting_next = 1'b1;
        end
        else if (sending_reg || start)
        begin
            // a colour set during a frame keeps waiting for the next one
            if (start)
            begin
                colour_waiting_next = 1'b0;
            end
            sending_next        = 1'b1;
            bit_shifter_next    = shifter_cur;
            line_next           = data_slot && (tick_cur < high_ticks);
            if (tick_cur == last_tick)
            begin
                tick_in_slot_next = '0;
                if (data_slot)
                begin
                    bit_shifter_next = shifter_cur << 1;
                end
                slot_index_next = slot_inc;
                if (slot_inc >= total)
                begin
                    sending_next    = 1'b0;
                    slot_index_next = '0;
                    done            = 1'b1;
                end
            end
            else
            begin
                slot_index_next   = slot_cur;
                tick_in_slot_next = tick_cur + TICK_W'(1);
            end
        end
        else
        begin
            // idle tick: hold the line low
            line_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_colour_reg <= '0;
            colour_waiting_reg <= 1'b0;
            sending_reg        <= 1'b0;
            bit_shifter_reg    <= '0;
            slot_index_reg     <= '0;
            tick_in_slot_reg   <= '0;
            line_reg           <= 1'b0;
        end
        else if (step)
        begin
            pending_colour_reg <= pending_colour_next;
            colour_waiting_reg <= colour_waiting_next;
            sending_reg        <= sending_next;
            bit_shifter_reg    <= bit_shifter_next;
            slot_index_reg     <= slot_index_next;
            tick_in_slot_reg   <= tick_in_slot_next;
            line_reg           <= line_next;
        end
    end

    assign result.line_level = line_next;
    assign result.busy_res   = sending_next;
    assign result.frame_done = done;

endmodule

`default_nettype wire

// ----- src/rgb_led_pulse_width_serializer.sv -----
// ----------------------------------------------------------------------------
// RGB LED pulse-width serialiser
// Turns timer-tick and set-colour beats into the one-wire line level.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tdata: red[7:0] green[15:8] blue[23:16]; tuser: opcode
//  m_*      | out       | tdata: line_level[0] busy_res[1]; tlast: frame_done
//  cfg_*    | in        | write enable, register index, 8-bit data
//
//  One beat in and one beat out per cycle while the output is not stalled; each
//  result is registered on its way out, through an output register and a skid stage.
//  A stalled output fills the skid stage, which drops s_tready until it drains.
//  Reset is asynchronous: configuration returns to its defaults, no colour
//  waits and the line is low.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_pulse_width_serializer
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [23:0]                       s_tdata,  // red, green, blue
    input  wire logic                              s_tuser,  // opcode
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,  // line_level, busy_res, zeros
    output logic                                   m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [rlps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rlps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rlps_pkg::*;

`include "rgb_led_pulse_width_serializer_defines.svh"

    logic         in_beat;
    logic         out_take;
    rlps_result_t step_res;
    rlps_result_t out_reg;
    rlps_result_t skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;

    assign s_tready = !skid_valid_reg;
    assign in_beat  = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    rlps_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (in_beat),
        .opcode    (s_tuser),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .result    (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // drain the skid stage first
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_beat)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_beat)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_reg <= step_res;
            end
            else
            begin
                out_reg <= step_res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.busy_res, out_reg.line_level};
    assign m_tlast  = out_reg.frame_done;

    `RLPS_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid stage holds a beat while the output register is empty")
    `RLPS_ASSERT_IMPL(a_done_not_busy, clk, rst_n, m_tvalid && m_tlast, !m_tdata[1],
        "frame end reported while still busy")
    `RLPS_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, in_beat && out_valid_reg && !m_tready,
        skid_valid_reg, "beat taken under output stall was not held")

endmodule

`default_nettype wire
